>>> design/bwl_pkg.sv
// ----------------------------------------------------------------------------
// bwl_pkg: shared types and constants for the binary window table filter
// Item and result words, the front-to-back queue entry, codes and helpers.
// ----------------------------------------------------------------------------
package bwl_pkg;

    // Sizes fixed by the item and result formats
    localparam int CFG_DW      = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int LUT_DEPTH   = 512;
    localparam int LUT_AW      = 9;
    localparam int LIT_W       = 21;
    localparam int QUEUE_DEPTH = 4;

    // Defaults for the frame size limits
    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 1024;

    // Register reset values
    localparam logic [CFG_DW-1:0] RESET_FRAME_WIDTH  = 11'd100;
    localparam logic [CFG_DW-1:0] RESET_FRAME_HEIGHT = 11'd100;

    // Item function codes
    localparam logic [1:0] FUNC_TABLE = 2'd0;
    localparam logic [1:0] FUNC_PIXEL = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_VALUE = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [LUT_AW-1:0] table_index;
        logic              table_bit;
        logic              pixel_in;
    } bwl_in_t;

    typedef struct packed {
        logic             pixel_out;
        logic             frame_last;
        logic [LIT_W-1:0] lit_count;
        logic             next_border;
    } bwl_out_t;

    typedef struct packed {
        logic [CFG_DW-1:0] frame_width;
        logic [CFG_DW-1:0] frame_height;
        logic              border_value;
    } bwl_cfg_t;

    // One classified word handed from the front to the back
    typedef struct packed {
        logic              is_table;    // table write, no stream effect
        logic [LUT_AW-1:0] table_index;
        logic              table_bit;
        logic [2:0]        col;         // top, mid, bottom of the new column
        logic              col_zero;    // first column of a row
        logic              early;       // emit the row end before the shift
        logic              late;        // emit after the shift
        logic              last;        // closes the frame
        logic              clear;       // frame restarted, drop the lit count
    } bwl_entry_t;

    // Window holds columns L (8..6), C (5..3), R (2..0), top row high.
    // Reorder into row-major table index with top-left as MSB.
    function automatic logic [LUT_AW-1:0] win_to_index(input logic [8:0] w);
        return {w[8], w[5], w[2], w[7], w[4], w[1], w[6], w[3], w[0]};
    endfunction

endpackage

>>> design/bwl_ram.sv
// ----------------------------------------------------------------------------
// bwl_ram: generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module bwl_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/bwl_front.sv
// ----------------------------------------------------------------------------
// bwl_front: item intake, stream position and line buffers
// Accepts items, tracks the raster position, reads and rewrites the two
// line buffers, and pushes one classified word per useful item.
// ----------------------------------------------------------------------------
module bwl_front
    import bwl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)(
    input  logic       clk,
    input  logic       rst_n,
    input  bwl_cfg_t   cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  bwl_in_t    in_data,
    output logic       push,
    output bwl_entry_t push_data,
    input  logic       full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [DW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [RW-1:0] h_plus1;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] pos_c;
    logic [RW-1:0] pos_r;
    logic [DW-1:0] c_inc;
    logic          restart, last, accept, is_stream, is_table;

    logic          s1_valid_reg;
    bwl_entry_t    s1_entry_reg;
    logic [CW-1:0] s1_addr_reg;
    logic          s1_rge1_reg, s1_rge2_reg, s1_rlth_reg, s1_pix_reg;
    logic          s1_fwd_reg;
    logic [1:0]    s1_fwd_data_reg;
    bwl_entry_t    f0_entry;

    logic [1:0]    lb_rdata, lb_data, lb_wdata;
    logic          top, mid, bot, s1_adv, lb_we, fwd_hit;

    // Clamp the frame size
    always_comb
    begin
        if (cfg.frame_width == '0)
            w_eff = DW'(1);
        else if (32'(cfg.frame_width) > 32'(MAX_WIDTH))
            w_eff = DW'(MAX_WIDTH);
        else
            w_eff = DW'(cfg.frame_width);

        if (cfg.frame_height == '0)
            h_eff = HW'(1);
        else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(cfg.frame_height);

        h_plus1 = RW'(h_eff) + RW'(1);
    end

    // Classify and place the incoming item
    always_comb
    begin
        is_table  = (in_data.func == FUNC_TABLE);
        is_stream = (in_data.func == FUNC_PIXEL) || (in_data.func == FUNC_FLUSH);
        accept    = in_valid && in_ready;

        restart = (DW'(col_reg) >= w_eff) || (row_reg > h_plus1);
        pos_c   = restart ? '0 : col_reg;
        pos_r   = restart ? '0 : row_reg;
        last    = (pos_c == '0) && (pos_r == h_plus1);
        c_inc   = DW'(pos_c) + DW'(1);

        if (last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (c_inc >= w_eff)
        begin
            col_next = '0;
            row_next = pos_r + RW'(1);
        end
        else
        begin
            col_next = CW'(c_inc);
            row_next = pos_r;
        end

        f0_entry             = '0;
        f0_entry.is_table    = is_table;
        f0_entry.table_index = in_data.table_index;
        f0_entry.table_bit   = in_data.table_bit;
        f0_entry.col_zero    = is_stream && (pos_c == '0);
        f0_entry.early       = is_stream && (pos_c == '0) && (pos_r >= RW'(2));
        f0_entry.late        = is_stream && (pos_c != '0) && (pos_r != '0);
        f0_entry.last        = is_stream && last;
        f0_entry.clear       = is_stream && restart;
    end

    // Advance the raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept && is_stream)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line buffer stage: build the new column and rewrite the buffers
    always_comb
    begin
        s1_adv   = s1_valid_reg && !full;
        in_ready = !s1_valid_reg || !full;
        lb_data  = s1_fwd_reg ? s1_fwd_data_reg : lb_rdata;
        top      = s1_rge2_reg ? lb_data[1] : cfg.border_value;
        mid      = s1_rge1_reg ? lb_data[0] : cfg.border_value;
        bot      = s1_rlth_reg ? s1_pix_reg : cfg.border_value;
        lb_wdata = {mid, bot};
        lb_we    = s1_adv && !s1_entry_reg.is_table && !s1_entry_reg.last;
        fwd_hit  = lb_we && (s1_addr_reg == pos_c);

        push          = s1_adv;
        push_data     = s1_entry_reg;
        push_data.col = {top, mid, bot};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= accept && (is_table || is_stream);
        end
    end

    // Hold the item payload and the write-to-read forward
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_entry_reg    <= f0_entry;
            s1_addr_reg     <= pos_c;
            s1_rge1_reg     <= (pos_r != '0);
            s1_rge2_reg     <= (pos_r >= RW'(2));
            s1_rlth_reg     <= (pos_r < RW'(h_eff));
            s1_pix_reg      <= (in_data.func == FUNC_PIXEL) && in_data.pixel_in;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= lb_wdata;
        end
    end

    // Upper and lower line buffers side by side: bit 1 upper, bit 0 lower
    bwl_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (lb_we),
        .waddr (s1_addr_reg),
        .wdata (lb_wdata),
        .re    (accept && is_stream),
        .raddr (pos_c),
        .rdata (lb_rdata)
    );

endmodule

>>> design/bwl_queue.sv
// ----------------------------------------------------------------------------
// bwl_queue: short word queue between front and back
// Register-based FIFO; full and valid come straight from the fill count.
// ----------------------------------------------------------------------------
module bwl_queue
    import bwl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  bwl_entry_t push_data,
    output logic       full,
    input  logic       pop,
    output logic       valid,
    output bwl_entry_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    bwl_entry_t    slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;

    assign full  = (count_reg == NW'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + NW'(1);
            else if (pop && !push)
                count_reg <= count_reg - NW'(1);
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("queue fill count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("pop from empty queue");

endmodule

>>> design/bwl_back.sv
// ----------------------------------------------------------------------------
// bwl_back: window, table lookup and result register
// Pops classified words, shifts the 3x3 window, looks up the table,
// keeps the lit count and holds the result until it is taken.
// ----------------------------------------------------------------------------
module bwl_back
    import bwl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       border_value,
    input  logic       q_valid,
    input  bwl_entry_t q_head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output bwl_out_t   out_data
);

    logic [8:0]        win_reg, win_next, win_shift;
    logic [2:0]        bcol;
    logic [LUT_AW-1:0] lut_raddr;
    logic              lut_rdata, lut_re, lut_we;
    logic              lut0_reg, lut511_reg;

    logic              lk_valid_reg, lk_emit_reg, lk_last_reg, lk_clear_reg;
    logic              lk_adv;
    logic [LIT_W-1:0]  lit_reg, lit_sum;

    logic              out_valid_reg;
    bwl_out_t          out_data_reg;

    // Window shift and lookup address
    always_comb
    begin
        bcol      = {3{border_value}};
        win_shift = {win_reg[5:0], bcol};
        if (q_head.col_zero)
            win_next = {bcol, bcol, q_head.col};
        else
            win_next = {win_reg[5:0], q_head.col};

        lk_adv = lk_valid_reg && (!lk_emit_reg || !out_valid_reg || out_ready);
        pop    = q_valid && (!lk_valid_reg || lk_adv);

        lut_we    = pop && q_head.is_table;
        lut_re    = pop && !q_head.is_table && (q_head.early || q_head.late);
        lut_raddr = win_to_index(q_head.early ? win_shift : win_next);

        lit_sum = (lk_clear_reg ? '0 : lit_reg) + LIT_W'(lk_emit_reg && lut_rdata);
    end

    // Update the window on stream words that do not close the frame
    always_ff @(posedge clk)
    begin
        if (pop && !q_head.is_table && !q_head.last)
        begin
            win_reg <= win_next;
        end
    end

    // Mirror the two all-border entries
    always_ff @(posedge clk)
    begin
        if (lut_we && (q_head.table_index == '0))
            lut0_reg <= q_head.table_bit;
        if (lut_we && (q_head.table_index == '1))
            lut511_reg <= q_head.table_bit;
    end

    bwl_ram #(
        .WIDTH (1),
        .DEPTH (LUT_DEPTH)
    ) u_lut_ram (
        .clk   (clk),
        .we    (lut_we),
        .waddr (q_head.table_index),
        .wdata (q_head.table_bit),
        .re    (lut_re),
        .raddr (lut_raddr),
        .rdata (lut_rdata)
    );

    // Lookup stage control and lit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lk_valid_reg  <= 1'b0;
            lk_emit_reg   <= 1'b0;
            lk_last_reg   <= 1'b0;
            lk_clear_reg  <= 1'b0;
            lit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!lk_valid_reg || lk_adv)
            begin
                lk_valid_reg <= pop && !q_head.is_table;
                lk_emit_reg  <= q_head.early || q_head.late;
                lk_last_reg  <= q_head.last;
                lk_clear_reg <= q_head.clear;
            end

            if (lk_adv)
                lit_reg <= lk_last_reg ? '0 : lit_sum;

            if (lk_adv && lk_emit_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (lk_adv && lk_emit_reg)
        begin
            out_data_reg.pixel_out   <= lut_rdata;
            out_data_reg.frame_last  <= lk_last_reg;
            out_data_reg.lit_count   <= lit_sum;
            out_data_reg.next_border <= border_value ? lut511_reg : lut0_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (lk_valid_reg && lk_last_reg) |-> lk_emit_reg)
        else $error("frame end word without a result");

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (lk_adv && lk_last_reg) |=> (lit_reg == '0))
        else $error("lit count not cleared after frame end");

    a_table_no_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_head.is_table) |=> !lk_valid_reg)
        else $error("table write entered lookup stage");

endmodule

>>> design/binary_window_lut_filter.sv
// Throughput: one item per clock while the output is not stalled, table writes and stream items alike.
// A result leaves the output register after the item that triggers it passes
// intake, line buffer read, queue and table read, each of them registered.
// The line buffer and table memories return registered read data.
// Reset clears position, queue, lit count and registers to their defaults;
// line buffers and the table come up undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// binary_window_lut_filter: 3x3 binary neighborhood table filter
// Config register file plus front intake, word queue and lookup back end.
// ----------------------------------------------------------------------------
module binary_window_lut_filter
    import bwl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bwl_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bwl_out_t             out_data
);

    bwl_cfg_t   cfg_reg;
    logic       q_push, q_full, q_pop, q_valid;
    bwl_entry_t q_push_data, q_head;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= RESET_FRAME_WIDTH;
            cfg_reg.frame_height <= RESET_FRAME_HEIGHT;
            cfg_reg.border_value <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data;
                CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                CFG_BORDER_VALUE: cfg_reg.border_value <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    bwl_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full)
    );

    bwl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    bwl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .border_value (cfg_reg.border_value),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule

>>> tb/sv/window_check_pkg.sv
// ----------------------------------------------------------------------------
// window_check_pkg: expected-result tracker for the binary window table filter
// Mirrors the filter's table, line buffers, window and frame position, turns
// each accepted input word into the result words it should cause, and checks
// the words that leave the block against them in order.
// ----------------------------------------------------------------------------
package window_check_pkg;

    import bwl_pkg::*;

    // Function code that the block ignores
    localparam logic [1:0] FUNC_IGNORED = 2'd3;

    class enhance_tracker;

        bit                lut [LUT_DEPTH];
        bit                upper_line [DEFAULT_MAX_WIDTH];
        bit                lower_line [DEFAULT_MAX_WIDTH];
        logic [8:0]        window;
        int unsigned       col_pos;
        int unsigned       row_pos;
        logic [LIT_W-1:0]  lit_total;
        logic [CFG_DW-1:0] frame_width;
        logic [CFG_DW-1:0] frame_height;
        logic              border;
        bwl_out_t          expected_pixels [$];
        int                errors;
        int                results_seen;

        function new();
            frame_width  = RESET_FRAME_WIDTH;
            frame_height = RESET_FRAME_HEIGHT;
            border       = 1'b0;
            errors       = 0;
            results_seen = 0;
            restart();
        endfunction

        function void restart();
            col_pos   = 0;
            row_pos   = 0;
            lit_total = '0;
            window    = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                CFG_FRAME_WIDTH:  frame_width  = data;
                CFG_FRAME_HEIGHT: frame_height = data;
                CFG_BORDER_VALUE: border       = data[0];
                default: ;
            endcase
        endfunction

        // Dimensions in use, clamped to 1..limit
        function int unsigned frame_cols();
            if (frame_width == 0)
                return 1;
            if (frame_width > DEFAULT_MAX_WIDTH)
                return DEFAULT_MAX_WIDTH;
            return frame_width;
        endfunction

        function int unsigned frame_rows();
            if (frame_height == 0)
                return 1;
            if (frame_height > DEFAULT_MAX_HEIGHT)
                return DEFAULT_MAX_HEIGHT;
            return frame_height;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Window is column-major (left column high, top row high in each);
        // the table address is row-major with the top-left as MSB
        function logic [LUT_AW-1:0] lut_address(logic [8:0] w);
            logic [LUT_AW-1:0] addr;
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    addr[8 - 3*r - k] = w[8 - 3*k - r];
            return addr;
        endfunction

        function void push_result(logic [8:0] w, logic last);
            bwl_out_t word;
            word.pixel_out   = lut[lut_address(w)];
            lit_total        = lit_total + word.pixel_out;
            word.frame_last  = last;
            word.lit_count   = lit_total;
            word.next_border = lut[border ? LUT_DEPTH-1 : 0];
            expected_pixels.push_back(word);
        endfunction

        // Advance the mirror by one accepted input word
        function void note_word(bwl_in_t word);
            int unsigned wd;
            int unsigned ht;
            int unsigned r;
            int unsigned c;
            logic [2:0]  bcol;
            logic [2:0]  column;
            logic        top;
            logic        mid;
            logic        bot;
            if (word.func == FUNC_TABLE) begin
                lut[word.table_index] = word.table_bit;
                return;
            end
            if (word.func == FUNC_IGNORED)
                return;
            wd = frame_cols();
            ht = frame_rows();
            // Restart when a register change left the position outside the frame
            if (col_pos >= wd || row_pos > ht + 1)
                restart();
            r    = row_pos;
            c    = col_pos;
            bcol = {3{border}};
            // Close the previous row with a border column on the right
            if (c == 0 && r >= 2) begin
                push_result({window[5:0], bcol}, r == ht + 1);
                if (r == ht + 1) begin
                    restart();
                    return;
                end
            end
            top = (r >= 2) ? upper_line[c] : border;
            mid = (r >= 1) ? lower_line[c] : border;
            if (r < ht)
                bot = (word.func == FUNC_PIXEL) ? word.pixel_in : 1'b0;
            else
                bot = border;
            upper_line[c] = mid;
            lower_line[c] = bot;
            column = {top, mid, bot};
            if (c == 0)
                window = {bcol, bcol, column};
            else
                window = {window[5:0], column};
            if (c >= 1 && r >= 1)
                push_result(window, 1'b0);
            col_pos = c + 1;
            if (col_pos >= wd) begin
                col_pos = 0;
                row_pos = r + 1;
            end
        endfunction

        task report(string msg);
            $display("ERROR result %0d: %s", results_seen, msg);
            errors++;
        endtask

        // Compare one result word with the oldest expectation
        task check_word(bwl_out_t got);
            bwl_out_t want;
            results_seen++;
            if (expected_pixels.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_out !== want.pixel_out)
                report($sformatf("pixel_out got %0b want %0b", got.pixel_out, want.pixel_out));
            if (got.frame_last !== want.frame_last)
                report($sformatf("frame_last got %0b want %0b",
                                 got.frame_last, want.frame_last));
            if (got.lit_count !== want.lit_count)
                report($sformatf("lit_count got %0d want %0d", got.lit_count, want.lit_count));
            if (got.next_border !== want.next_border)
                report($sformatf("next_border got %0b want %0b",
                                 got.next_border, want.next_border));
        endtask

    endclass

endpackage

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for binary_window_lut_filter
// Loads the whole table, runs a few hand-built frames (clamped sizes, flush
// inside the frame, pixels past the frame, ignored words, a frame cut short
// by a width change), then random frames with table rewrites and cut-short
// frames under changing idle and stall rates.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bwl_pkg::*;
    import window_check_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_WORDS  = 970;
    localparam int MAX_GAP       = 24;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DW-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    bwl_in_t              in_data;
    logic                 out_valid;
    logic                 out_ready;
    bwl_out_t             out_data;

    int             sender_pct;
    int             stall_pct;
    int             stream_words;
    int             table_words;
    int             settings;
    enhance_tracker board;

    binary_window_lut_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Check each accepted result word, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_word(out_data);
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // End the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word accepted for %0d cycles", QUIET_LIMIT);
        $display("binary_window_lut_filter: mismatch");
        $finish;
    end

    // Offer one input word after a random idle gap and hold it until taken
    task automatic send_word(input bwl_in_t word);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_word(word);
        if (word.func == FUNC_TABLE)
            table_words++;
        else if (word.func != FUNC_IGNORED)
            stream_words++;
    endtask

    task automatic write_lut(input logic [LUT_AW-1:0] idx, input logic value);
        bwl_in_t word;
        word.func        = FUNC_TABLE;
        word.table_index = idx;
        word.table_bit   = value;
        word.pixel_in    = 1'($urandom_range(1));
        send_word(word);
    endtask

    // Pixel, flush or ignored word; unused fields carry random bits
    task automatic send_stream(input logic [1:0] func, input logic pix);
        bwl_in_t word;
        word.func        = func;
        word.table_index = LUT_AW'($urandom_range(LUT_DEPTH-1));
        word.table_bit   = 1'($urandom_range(1));
        word.pixel_in    = pix;
        send_word(word);
    endtask

    // Drop valid, wait out every expected result and the pipeline tail
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.set_register(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                             input logic b);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_BORDER_VALUE, {{(CFG_DW-1){1'b0}}, b});
        settings++;
    endtask

    // One frame of random pixels and its flush tail, with table rewrites,
    // dark flushes inside and pixels past the frame mixed in; a cut frame
    // stops mid-row so that the next width change restarts it
    task automatic run_frame(input bit cut_short);
        int unsigned wd;
        int unsigned ht;
        int unsigned total;
        int unsigned cut;
        bit          stop;
        wd    = board.frame_cols();
        ht    = board.frame_rows();
        total = wd * ht + wd + 1;
        cut   = cut_short ? $urandom_range(1, total - 1) : total;
        stop  = 1'b0;
        for (int unsigned k = 0; k < total && !stop; k++)
        begin
            if (k == cut && board.col_pos != 0)
                stop = 1'b1;
            else
            begin
                if ($urandom_range(99) < 4)
                    write_lut(LUT_AW'($urandom_range(LUT_DEPTH-1)),
                              1'($urandom_range(1)));
                if (k < wd * ht)
                    send_stream(($urandom_range(99) < 5) ? FUNC_FLUSH : FUNC_PIXEL,
                                1'($urandom_range(1)));
                else
                    send_stream(($urandom_range(99) < 20) ? FUNC_PIXEL : FUNC_FLUSH,
                                1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        int                random_start;
        int                frame_no;
        logic [CFG_DW-1:0] w_raw;
        logic [CFG_DW-1:0] h_raw;
        board        = new();
        sender_pct   = 0;
        stall_pct    = 0;
        stream_words = 0;
        table_words  = 0;
        settings     = 0;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every table entry so no lookup reads an unwritten one
        for (int i = 0; i < LUT_DEPTH; i++)
            write_lut(LUT_AW'(i), 1'($urandom_range(1)));
        drain();

        // 3x2 frame: dark flush inside, table rewrites of both border
        // entries mid-frame, an ignored pixel past the frame, an ignored word
        set_frame(11'd3, 11'd2, 1'b0);
        send_stream(FUNC_PIXEL, 1'b1);
        send_stream(FUNC_PIXEL, 1'b0);
        send_stream(FUNC_PIXEL, 1'b1);
        send_stream(FUNC_FLUSH, 1'b1);
        send_stream(FUNC_PIXEL, 1'b1);
        send_stream(FUNC_PIXEL, 1'b1);
        write_lut(9'd0, ~board.lut[0]);
        write_lut(9'd511, ~board.lut[LUT_DEPTH-1]);
        send_stream(FUNC_PIXEL, 1'b1);
        send_stream(FUNC_IGNORED, 1'b1);
        send_stream(FUNC_FLUSH, 1'b0);
        send_stream(FUNC_FLUSH, 1'b0);
        send_stream(FUNC_FLUSH, 1'b0);
        drain();

        // Zero sizes clamp to a single pixel; lit border
        set_frame(11'd0, 11'd0, 1'b1);
        send_stream(FUNC_PIXEL, 1'b1);
        send_stream(FUNC_FLUSH, 1'b0);
        send_stream(FUNC_FLUSH, 1'b1);
        drain();

        // Stop mid-row, then narrow the frame so that it restarts
        set_frame(11'd3, 11'd2, 1'b0);
        repeat (5) send_stream(FUNC_PIXEL, 1'($urandom_range(1)));
        drain();
        set_frame(11'd2, 11'd1, 1'b0);
        send_stream(FUNC_PIXEL, 1'b1);
        send_stream(FUNC_PIXEL, 1'b0);
        repeat (3) send_stream(FUNC_FLUSH, 1'b0);
        drain();

        // Random frames, rotating through the idle and stall mixes
        random_start = stream_words;
        frame_no     = 0;
        while (stream_words - random_start < RANDOM_WORDS)
        begin
            case (frame_no % 4)
                0: begin sender_pct = 0;  stall_pct = 0;  end
                1: begin sender_pct = 56; stall_pct = 0;  end
                2: begin sender_pct = 0;  stall_pct = 56; end
                default: begin sender_pct = 34; stall_pct = 34; end
            endcase
            frame_no++;
            drain();
            // A cut frame needs a width no larger than its column to restart
            if (board.col_pos != 0)
                w_raw = 11'($urandom_range(1, (board.col_pos < 12) ? board.col_pos : 12));
            else
                w_raw = ($urandom_range(19) == 0) ? 11'd0 : 11'($urandom_range(1, 12));
            h_raw = ($urandom_range(19) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
            set_frame(w_raw, h_raw, 1'($urandom_range(1)));
            run_frame($urandom_range(9) == 0);
        end
        drain();

        $display("covered %0d stream words and %0d table writes over %0d frame settings",
                 stream_words, table_words, settings);
        $display("%0d result words checked, %0d field errors",
                 board.results_seen, board.errors);
        if (board.errors == 0)
            $display("binary_window_lut_filter: match");
        else
            $display("binary_window_lut_filter: mismatch");
        $finish;
    end

endmodule
